// File: sv/cfa_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and sequencer states of the contiguous fit allocator.
package cfa_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int ADDR_BITS_DEF    = 20;
  localparam int OWNER_BITS_DEF   = 16;

  localparam int CFG_W  = 21;
  localparam int ID_W   = 16;
  localparam int REQ_W  = 21;
  localparam int OP_W   = 2;
  localparam int MODE_W = 2;
  localparam int CODE_W = 2;

  localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPACT = 2'd2;
  localparam logic [OP_W-1:0] OP_STATUS  = 2'd3;

  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  localparam logic [CODE_W-1:0] RES_OK       = 2'd0;
  localparam logic [CODE_W-1:0] RES_NOMEM    = 2'd1;
  localparam logic [CODE_W-1:0] RES_NOTFOUND = 2'd2;
  localparam logic [CODE_W-1:0] RES_FULL     = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHUP,
    ST_SPLIT_LO,
    ST_SPLIT_HI,
    ST_NBR,
    ST_MERGE,
    ST_SHDN,
    ST_PACK,
    ST_PACK_TAIL,
    ST_LIST
  } cfa_state_e;

endpackage

// File: sv/cfa_fit_unit.sv
`timescale 1ns / 1ps
// Shared segment size and fit compare unit.
module cfa_fit_unit import cfa_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic [ADDR_BITS-1:0] seg_start_i,
  input  logic [ADDR_BITS-1:0] seg_end_i,
  input  logic                 seg_used_i,
  input  logic [REQ_W-1:0]     want_i,
  input  logic [MODE_W-1:0]    mode_i,
  input  logic [ADDR_BITS:0]   best_i,
  output logic [ADDR_BITS:0]   size_o,
  output logic                 fits_o,
  output logic                 better_o
);

  localparam int SW = ADDR_BITS + 1;
  localparam int CW = (SW > REQ_W) ? SW : REQ_W;

  logic [CW-1:0] size_cw;
  logic [CW-1:0] want_cw;

  assign size_o  = SW'(seg_end_i) - SW'(seg_start_i) + SW'(1);
  assign size_cw = CW'(size_o);
  assign want_cw = CW'(want_i);
  assign fits_o  = !seg_used_i && (size_cw >= want_cw);

  always_comb begin
    case (mode_i)
      FIT_BEST:  better_o = (size_o < best_i);
      FIT_WORST: better_o = (size_o > best_i);
      default:   better_o = 1'b0;
    endcase
  end

endmodule

// File: sv/contiguous_fit_allocator.sv
`timescale 1ns / 1ps
// Contiguous fit allocator: segment table, sequencer and result register.
// Request: a scan of the table, then a shift of entries up to open a split; release:
// a scan, a read of the neighbors and a merge, then a shift down to close the gap;
// compact: one packing pass and a tail write; status emits one segment per cycle.
// One command at a time: busy until its last result; the receiver cannot stall results.
// The segment memory, read one entry a cycle, sets the pace of every pass.
// Reset: one free segment of min(1048576, 2^ADDR_BITS) units; no clearing pass.
module contiguous_fit_allocator import cfa_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  parameter int OWNER_BITS   = OWNER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       op_i,
  input  logic [ID_W-1:0]       proc_id_i,
  input  logic [REQ_W-1:0]      req_size_i,
  input  logic [MODE_W-1:0]     fit_mode_i,
  output logic                  result_valid_o,
  output logic [CODE_W-1:0]     code_o,
  output logic [ADDR_BITS-1:0]  base_o,
  output logic [ADDR_BITS-1:0]  limit_o,
  output logic                  in_use_o,
  output logic [OWNER_BITS-1:0] owner_o,
  output logic                  last_o
);

  localparam int AW   = ADDR_BITS;
  localparam int OB   = OWNER_BITS;
  localparam int SW   = AW + 1;                 // size of a segment, up to 2^AW
  localparam int CW   = (SW > CFG_W) ? SW : CFG_W;
  localparam int IW   = $clog2(MAX_SEGMENTS);
  localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0]   CAP      = CW'(1) << AW;
  localparam logic [CW-1:0]   RST_REQ  = CW'(1048576);
  localparam logic [SW-1:0]   RST_SPACE = (RST_REQ > CAP) ? SW'(CAP) : SW'(RST_REQ);
  localparam logic [CNTW-1:0] MAX_CNT  = CNTW'(MAX_SEGMENTS);

  typedef struct packed {
    logic          used;
    logic [OB-1:0] owner;
    logic [AW-1:0] seg_start;
    logic [AW-1:0] seg_end;
  } seg_t;

  // Segment memory: one write and one registered read per cycle.
  seg_t          mem_q [MAX_SEGMENTS];
  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  seg_t          wdata;
  seg_t          rdata_q;
  logic          rvld_q, rfresh_q;
  logic [IW-1:0] ridx_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  cfa_state_e state_q, state_d;

  logic [OP_W-1:0]   op_q, op_d;
  logic [OB-1:0]     id_q, id_d;
  logic [REQ_W-1:0]  want_q, want_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic [SW-1:0]     space_q, space_d;
  logic              init_q, init_d;      // table is fresh: entry 0 reads as the whole space
  logic [IW-1:0]     iss_q, iss_d;
  logic [CNTW-1:0]   left_q, left_d;
  logic              found_q, found_d;
  logic [IW-1:0]     pick_q, pick_d;
  logic [AW-1:0]     pstart_q, pstart_d, pend_q, pend_d;
  logic [SW-1:0]     psize_q, psize_d;
  logic              prevf_q, prevf_d, nextf_q, nextf_d;
  logic [AW-1:0]     nstart_q, nstart_d, nend_q, nend_d;
  logic [1:0]        k_q, k_d;
  logic [SW-1:0]     gap_q, gap_d;
  logic [CNTW-1:0]   w_q, w_d;

  logic              rv_q, rv_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic [AW-1:0]     base_q, base_d, lim_q, lim_d;
  logic              use_q, use_d, last_q, last_d;
  logic [OB-1:0]     own_q, own_d;

  // Owner id is the low OWNER_BITS of proc_id, zero-extended if wider.
  logic [OB+ID_W-1:0] id_ext;
  logic [OB-1:0]      id_in;
  assign id_ext = {{OB{1'b0}}, proc_id_i};
  assign id_in  = id_ext[OB-1:0];

  // Clamp of a written memory size to [1, 2^AW].
  logic [CW-1:0] cfg_cw;
  logic [SW-1:0] cfg_space;
  always_comb begin
    cfg_cw = CW'(cfg_wdata_i);
    if (cfg_cw == '0) begin
      cfg_cw = CW'(1);
    end
    cfg_space = (cfg_cw > CAP) ? SW'(CAP) : SW'(cfg_cw);
  end

  // Entry returned by the memory, with the fresh-table override on entry 0.
  seg_t rent;
  always_comb begin
    rent = rdata_q;
    if (rfresh_q) begin
      rent.used      = 1'b0;
      rent.owner     = '0;
      rent.seg_start = '0;
      rent.seg_end   = AW'(space_q - SW'(1));
    end
  end

  logic [SW-1:0] fu_size;
  logic          fu_fits, fu_better;

  cfa_fit_unit #(
    .ADDR_BITS(ADDR_BITS)
  ) u_fit (
    .seg_start_i(rent.seg_start),
    .seg_end_i  (rent.seg_end),
    .seg_used_i (rent.used),
    .want_i     (want_q),
    .mode_i     (mode_q),
    .best_i     (psize_q),
    .size_o     (fu_size),
    .fits_o     (fu_fits),
    .better_o   (fu_better)
  );

  logic [CW-1:0] want_cw;
  logic [AW-1:0] want_a;
  logic          stream_done;
  logic          take;
  logic [IW-1:0] nbr_lo, nbr_hi, dst;
  logic [1:0]    k_now;

  assign want_cw     = CW'(want_q);
  assign want_a      = want_cw[AW-1:0];
  assign stream_done = (left_q == '0) && !rvld_q;
  assign take        = (op_q == OP_RELEASE)
                       ? (rent.used && (rent.owner == id_q) && !found_q)
                       : (fu_fits && (!found_q || fu_better));
  assign nbr_lo      = (pick_q == '0) ? pick_q : pick_q - IW'(1);
  assign nbr_hi      = ((CNTW'(pick_q) + CNTW'(1)) < cnt_q) ? pick_q + IW'(1) : pick_q;
  assign dst         = prevf_q ? pick_q - IW'(1) : pick_q;
  assign k_now       = {1'b0, prevf_q} + {1'b0, nextf_q};
  assign busy        = (state_q != ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (op_i)
            OP_REQUEST: begin
              if (req_size_i != '0 && fit_mode_i <= FIT_WORST) begin
                state_d = ST_SCAN;
              end
            end
            OP_RELEASE: state_d = ST_SCAN;
            OP_COMPACT: state_d = ST_PACK;
            default:    state_d = ST_LIST;
          endcase
        end
      end
      ST_SCAN:      if (stream_done) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (!found_q) begin
          state_d = ST_IDLE;
        end else if (op_q == OP_RELEASE) begin
          state_d = ST_NBR;
        end else if (CW'(psize_q) == want_cw || cnt_q >= MAX_CNT) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SHUP;
        end
      end
      ST_SHUP:      if (stream_done) state_d = ST_SPLIT_LO;
      ST_SPLIT_LO:  state_d = ST_SPLIT_HI;
      ST_SPLIT_HI:  state_d = ST_IDLE;
      ST_NBR:       if (stream_done) state_d = ST_MERGE;
      ST_MERGE:     state_d = (k_now == 2'd0) ? ST_IDLE : ST_SHDN;
      ST_SHDN:      if (stream_done) state_d = ST_IDLE;
      ST_PACK:      if (stream_done) state_d = ST_PACK_TAIL;
      ST_PACK_TAIL: state_d = ST_IDLE;
      ST_LIST:      if (stream_done) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory access and result loading.
  always_comb begin
    op_d = op_q;  id_d = id_q;  want_d = want_q;  mode_d = mode_q;
    cnt_d = cnt_q;  space_d = space_q;  init_d = init_q;
    iss_d = iss_q;  left_d = left_q;
    found_d = found_q;  pick_d = pick_q;  pstart_d = pstart_q;  pend_d = pend_q;
    psize_d = psize_q;
    prevf_d = prevf_q;  nextf_d = nextf_q;  nstart_d = nstart_q;  nend_d = nend_q;
    k_d = k_q;  gap_d = gap_q;  w_d = w_q;
    rv_d = 1'b0;  code_d = code_q;  base_d = base_q;  lim_d = lim_q;
    use_d = use_q;  own_d = own_q;  last_d = last_q;
    we = 1'b0;  waddr = '0;  wdata = '0;
    re = 1'b0;  raddr = iss_q;

    // Streaming states issue one read per cycle until left runs out.
    if (state_q == ST_SCAN || state_q == ST_SHUP || state_q == ST_NBR ||
        state_q == ST_SHDN || state_q == ST_PACK || state_q == ST_LIST) begin
      if (left_q != '0) begin
        re     = 1'b1;
        left_d = left_q - CNTW'(1);
        iss_d  = (state_q == ST_SHUP) ? iss_q - IW'(1) : iss_q + IW'(1);
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          space_d = cfg_space;
          cnt_d   = CNTW'(1);
          init_d  = 1'b1;
        end
        if (start) begin
          op_d = op_i;  id_d = id_in;  want_d = req_size_i;  mode_d = fit_mode_i;
          iss_d = '0;  left_d = cnt_q;  found_d = 1'b0;  psize_d = '0;
          gap_d = '0;  w_d = '0;
          if (op_i == OP_REQUEST && (req_size_i == '0 || fit_mode_i > FIT_WORST)) begin
            rv_d = 1'b1;  code_d = RES_NOMEM;  base_d = '0;  lim_d = '0;
            use_d = 1'b0;  own_d = '0;  last_d = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (rvld_q && take) begin
          found_d  = 1'b1;
          pick_d   = ridx_q;
          pstart_d = rent.seg_start;
          pend_d   = rent.seg_end;
          psize_d  = fu_size;
        end
      end
      ST_DECIDE: begin
        base_d = '0;  lim_d = '0;  use_d = 1'b0;  own_d = '0;  last_d = 1'b1;
        if (!found_q) begin
          rv_d   = 1'b1;
          code_d = (op_q == OP_RELEASE) ? RES_NOTFOUND : RES_NOMEM;
        end else if (op_q == OP_RELEASE) begin
          iss_d   = nbr_lo;
          left_d  = CNTW'(nbr_hi) - CNTW'(nbr_lo) + CNTW'(1);
          prevf_d = 1'b0;
          nextf_d = 1'b0;
        end else if (CW'(psize_q) == want_cw) begin
          we     = 1'b1;
          waddr  = pick_q;
          wdata  = '{used: 1'b1, owner: id_q, seg_start: pstart_q, seg_end: pend_q};
          rv_d   = 1'b1;  code_d = RES_OK;  base_d = pstart_q;  lim_d = pend_q;
          use_d  = 1'b1;  own_d = id_q;
          if (pick_q == '0) init_d = 1'b0;
        end else if (cnt_q >= MAX_CNT) begin
          rv_d   = 1'b1;
          code_d = RES_FULL;
        end else begin
          iss_d  = IW'(cnt_q - CNTW'(1));
          left_d = cnt_q - CNTW'(1) - CNTW'(pick_q);
        end
      end
      ST_SHUP: begin
        if (rvld_q) begin
          we    = 1'b1;
          waddr = ridx_q + IW'(1);
          wdata = rent;
        end
      end
      ST_SPLIT_LO: begin
        we    = 1'b1;
        waddr = pick_q;
        wdata = '{used: 1'b1, owner: id_q, seg_start: pstart_q,
                  seg_end: pstart_q + want_a - AW'(1)};
        if (pick_q == '0) init_d = 1'b0;
      end
      ST_SPLIT_HI: begin
        we     = 1'b1;
        waddr  = pick_q + IW'(1);
        wdata  = '{used: 1'b0, owner: '0, seg_start: pstart_q + want_a, seg_end: pend_q};
        cnt_d  = cnt_q + CNTW'(1);
        rv_d   = 1'b1;  code_d = RES_OK;  base_d = pstart_q;
        lim_d  = pstart_q + want_a - AW'(1);
        use_d  = 1'b1;  own_d = id_q;  last_d = 1'b1;
      end
      ST_NBR: begin
        if (rvld_q && ridx_q < pick_q) begin
          prevf_d  = !rent.used;
          nstart_d = rent.seg_start;
        end
        if (rvld_q && ridx_q > pick_q) begin
          nextf_d = !rent.used;
          nend_d  = rent.seg_end;
        end
      end
      ST_MERGE: begin
        we    = 1'b1;
        waddr = dst;
        wdata = '{used: 1'b0, owner: '0,
                  seg_start: prevf_q ? nstart_q : pstart_q,
                  seg_end: nextf_q ? nend_q : pend_q};
        if (dst == '0) init_d = 1'b0;
        k_d    = k_now;
        iss_d  = IW'(CNTW'(dst) + CNTW'(1) + CNTW'(k_now));
        left_d = cnt_q - CNTW'(1) - CNTW'(k_now) - CNTW'(dst);
        if (k_now == 2'd0) begin
          rv_d  = 1'b1;  code_d = RES_OK;  base_d = pstart_q;  lim_d = pend_q;
          use_d = 1'b0;  own_d = id_q;  last_d = 1'b1;
        end
      end
      ST_SHDN: begin
        if (rvld_q) begin
          we    = 1'b1;
          waddr = ridx_q - IW'(k_q);
          wdata = rent;
        end
        if (stream_done) begin
          cnt_d = cnt_q - CNTW'(k_q);
          rv_d  = 1'b1;  code_d = RES_OK;  base_d = pstart_q;  lim_d = pend_q;
          use_d = 1'b0;  own_d = id_q;  last_d = 1'b1;
        end
      end
      ST_PACK: begin
        if (rvld_q) begin
          if (rent.used) begin
            we    = 1'b1;
            waddr = w_q[IW-1:0];
            wdata = '{used: 1'b1, owner: rent.owner,
                      seg_start: rent.seg_start - AW'(gap_q),
                      seg_end: rent.seg_end - AW'(gap_q)};
            w_d   = w_q + CNTW'(1);
            if (w_q == '0) init_d = 1'b0;
          end else begin
            gap_d = gap_q + fu_size;
          end
        end
      end
      ST_PACK_TAIL: begin
        cnt_d = w_q;
        if (gap_q != '0 && w_q < MAX_CNT) begin
          we    = 1'b1;
          waddr = w_q[IW-1:0];
          wdata = '{used: 1'b0, owner: '0, seg_start: AW'(space_q - gap_q),
                    seg_end: AW'(space_q - SW'(1))};
          cnt_d = w_q + CNTW'(1);
          if (w_q == '0) init_d = 1'b0;
        end
        rv_d  = 1'b1;  code_d = RES_OK;  base_d = '0;  lim_d = '0;
        use_d = 1'b0;  own_d = '0;  last_d = 1'b1;
      end
      ST_LIST: begin
        if (rvld_q) begin
          rv_d   = 1'b1;
          code_d = RES_OK;
          base_d = rent.seg_start;
          lim_d  = rent.seg_end;
          use_d  = rent.used;
          own_d  = rent.used ? rent.owner : '0;
          last_d = (CNTW'(ridx_q) + CNTW'(1)) == cnt_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= CNTW'(1);
      space_q  <= RST_SPACE;
      init_q   <= 1'b1;
      left_q   <= '0;
      rvld_q   <= 1'b0;
      rfresh_q <= 1'b0;
      rv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      space_q  <= space_d;
      init_q   <= init_d;
      left_q   <= left_d;
      rvld_q   <= re;
      rfresh_q <= re && init_q && (raddr == '0);
      rv_q     <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q   <= raddr;
    op_q     <= op_d;
    id_q     <= id_d;
    want_q   <= want_d;
    mode_q   <= mode_d;
    iss_q    <= iss_d;
    found_q  <= found_d;
    pick_q   <= pick_d;
    pstart_q <= pstart_d;
    pend_q   <= pend_d;
    psize_q  <= psize_d;
    prevf_q  <= prevf_d;
    nextf_q  <= nextf_d;
    nstart_q <= nstart_d;
    nend_q   <= nend_d;
    k_q      <= k_d;
    gap_q    <= gap_d;
    w_q      <= w_d;
    code_q   <= code_d;
    base_q   <= base_d;
    lim_q    <= lim_d;
    use_q    <= use_d;
    own_q    <= own_d;
    last_q   <= last_d;
  end

  assign result_valid_o = rv_q;
  assign code_o         = code_q;
  assign base_o         = base_q;
  assign limit_o        = lim_q;
  assign in_use_o       = use_q;
  assign owner_o        = own_q;
  assign last_o         = last_q;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= MAX_CNT))
    else $error("segment count out of range");

  a_multi_only_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> (state_q == ST_LIST))
    else $error("non-final result outside status listing");

  a_read_in_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvld_q |-> (state_q == ST_SCAN || state_q == ST_SHUP || state_q == ST_NBR ||
                state_q == ST_SHDN || state_q == ST_PACK || state_q == ST_LIST))
    else $error("read data returned outside a streaming state");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (waddr != raddr))
    else $error("segment memory read and write at one address");
`endif

endmodule

// File: tb/contiguous_fit_allocator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the contiguous fit allocator.
module contiguous_fit_allocator_test;
  import cfa_pkg::*;

  localparam int  SEG_MAX    = MAX_SEGMENTS_DEF;
  localparam int  SPACE_CAP  = 1 << ADDR_BITS_DEF;
  localparam int  CYCLE_CAP  = 800000;
  localparam int  SETTLE     = 8;    // idle cycles before a register write
  localparam int  TAIL_WAIT  = 200;

  typedef enum logic [1:0] {K_CMD, K_CFG, K_DRAIN} entry_kind_e;

  typedef struct {
    entry_kind_e       kind;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [REQ_W-1:0]  size;
    logic [MODE_W-1:0] mode;
    logic [CFG_W-1:0]  cfg;
    int                gap;
  } entry_t;

  typedef struct {
    logic [CODE_W-1:0]         code;
    logic [ADDR_BITS_DEF-1:0]  base;
    logic [ADDR_BITS_DEF-1:0]  limit;
    logic                      in_use;
    logic [OWNER_BITS_DEF-1:0] owner;
    logic                      last;
  } segment_report_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic start, busy;
  logic [OP_W-1:0] op_i;
  logic [ID_W-1:0] proc_id_i;
  logic [REQ_W-1:0] req_size_i;
  logic [MODE_W-1:0] fit_mode_i;
  logic result_valid_o;
  logic [CODE_W-1:0] code_o;
  logic [ADDR_BITS_DEF-1:0] base_o, limit_o;
  logic in_use_o;
  logic [OWNER_BITS_DEF-1:0] owner_o;
  logic last_o;

  contiguous_fit_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .start(start), .busy(busy),
    .op_i(op_i), .proc_id_i(proc_id_i), .req_size_i(req_size_i), .fit_mode_i(fit_mode_i),
    .result_valid_o(result_valid_o), .code_o(code_o), .base_o(base_o), .limit_o(limit_o),
    .in_use_o(in_use_o), .owner_o(owner_o), .last_o(last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Shadow segment table kept by the predictor.
  longint seg_lo [SEG_MAX];
  longint seg_hi [SEG_MAX];
  longint seg_own [SEG_MAX];
  bit     seg_used [SEG_MAX];
  int     seg_cnt;
  longint space_units;

  entry_t          pending_q[$];
  segment_report_t expected_q[$];
  int              mismatches;
  int              cycles;

  function automatic void push_report(logic [CODE_W-1:0] code, longint base, longint limit,
                                      bit used, longint owner, bit last);
    segment_report_t r;
    r.code = code;
    r.base = base[ADDR_BITS_DEF-1:0];
    r.limit = limit[ADDR_BITS_DEF-1:0];
    r.in_use = used;
    r.owner = owner[OWNER_BITS_DEF-1:0];
    r.last = last;
    expected_q.push_back(r);
  endfunction

  function automatic void table_reset(logic [CFG_W-1:0] value);
    longint sz;
    sz = value;
    if (sz == 0) sz = 1;
    if (sz > SPACE_CAP) sz = SPACE_CAP;
    space_units = sz;
    for (int i = 0; i < SEG_MAX; i++) begin
      seg_lo[i] = 0; seg_hi[i] = 0; seg_own[i] = 0; seg_used[i] = 0;
    end
    seg_hi[0] = sz - 1;
    seg_cnt = 1;
  endfunction

  function automatic longint seg_len(int i);
    return seg_hi[i] - seg_lo[i] + 1;
  endfunction

  function automatic void drop_segment(int i);
    for (int j = i; j + 1 < seg_cnt; j++) begin
      seg_lo[j] = seg_lo[j+1]; seg_hi[j] = seg_hi[j+1];
      seg_own[j] = seg_own[j+1]; seg_used[j] = seg_used[j+1];
    end
    seg_cnt--;
  endfunction

  function automatic void place_block(longint id, longint want, logic [MODE_W-1:0] mode);
    int pick;
    bit found;
    longint s;
    pick = 0;
    found = 0;
    if (want == 0 || mode > FIT_WORST) begin
      push_report(RES_NOMEM, 0, 0, 0, 0, 1);
      return;
    end
    for (int i = 0; i < seg_cnt; i++) begin
      if (seg_used[i]) continue;
      s = seg_len(i);
      if (s < want) continue;
      if (!found || (mode == FIT_BEST && s < seg_len(pick)) ||
          (mode == FIT_WORST && s > seg_len(pick))) begin
        pick = i;
        found = 1;
        if (mode == FIT_FIRST) break;
      end
    end
    if (!found) begin
      push_report(RES_NOMEM, 0, 0, 0, 0, 1);
      return;
    end
    if (seg_len(pick) != want) begin
      if (seg_cnt >= SEG_MAX) begin
        push_report(RES_FULL, 0, 0, 0, 0, 1);
        return;
      end
      for (int j = seg_cnt; j > pick; j--) begin
        seg_lo[j] = seg_lo[j-1]; seg_hi[j] = seg_hi[j-1];
        seg_own[j] = seg_own[j-1]; seg_used[j] = seg_used[j-1];
      end
      seg_cnt++;
      seg_hi[pick] = seg_lo[pick] + want - 1;
      seg_lo[pick+1] = seg_hi[pick] + 1;
    end
    seg_used[pick] = 1;
    seg_own[pick] = id;
    push_report(RES_OK, seg_lo[pick], seg_hi[pick], 1, id, 1);
  endfunction

  function automatic void free_block(longint id);
    int i;
    longint lo, hi;
    for (i = 0; i < seg_cnt; i++)
      if (seg_used[i] && seg_own[i] == id) break;
    if (i >= seg_cnt) begin
      push_report(RES_NOTFOUND, 0, 0, 0, 0, 1);
      return;
    end
    lo = seg_lo[i];
    hi = seg_hi[i];
    seg_used[i] = 0;
    seg_own[i] = 0;
    if (i + 1 < seg_cnt && !seg_used[i+1]) begin
      seg_lo[i+1] = seg_lo[i];
      drop_segment(i);
    end
    if (i > 0 && !seg_used[i-1]) begin
      seg_hi[i-1] = seg_hi[i];
      drop_segment(i);
    end
    push_report(RES_OK, lo, hi, 0, id, 1);
  endfunction

  function automatic void pack_blocks();
    int w;
    longint gap;
    w = 0;
    gap = 0;
    for (int r = 0; r < seg_cnt; r++) begin
      if (seg_used[r]) begin
        seg_lo[w] = seg_lo[r] - gap; seg_hi[w] = seg_hi[r] - gap;
        seg_own[w] = seg_own[r]; seg_used[w] = 1;
        w++;
      end else begin
        gap += seg_len(r);
      end
    end
    // freed space always ends up as one trailing hole, used tail or not
    if (gap > 0 && w < SEG_MAX) begin
      seg_lo[w] = space_units - gap; seg_hi[w] = space_units - 1;
      seg_own[w] = 0; seg_used[w] = 0;
      w++;
    end
    seg_cnt = w;
    push_report(RES_OK, 0, 0, 0, 0, 1);
  endfunction

  function automatic void predict_command(entry_t e);
    case (e.op)
      OP_REQUEST: place_block(e.id, e.size, e.mode);
      OP_RELEASE: free_block(e.id);
      OP_COMPACT: pack_blocks();
      default: begin
        for (int i = 0; i < seg_cnt; i++)
          push_report(RES_OK, seg_lo[i], seg_hi[i], seg_used[i],
                      seg_used[i] ? seg_own[i] : 0, i + 1 == seg_cnt);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Monitor: checks each result transfer, then books any command transfer.
  entry_t in_flight;
  bit     took;

  always @(posedge clk_i) begin
    segment_report_t x;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result code", code_o, 0);
        end else begin
          x = expected_q.pop_front();
          if (code_o !== x.code) report_mismatch("code", code_o, x.code);
          if (base_o !== x.base) report_mismatch("base", base_o, x.base);
          if (limit_o !== x.limit) report_mismatch("limit", limit_o, x.limit);
          if (in_use_o !== x.in_use) report_mismatch("in_use", in_use_o, x.in_use);
          if (owner_o !== x.owner) report_mismatch("owner", owner_o, x.owner);
          if (last_o !== x.last) report_mismatch("last", last_o, x.last);
        end
      end
      if (start && !busy) begin
        predict_command(in_flight);
        took = 1;
      end
    end
  end

  // Driver: presents pending entries at the falling edge.
  int gap_left;
  int idle_run;

  always @(negedge clk_i) begin
    entry_t e;
    if (rst_ni) begin
      cfg_we_i = 1'b0;
      if (start && took) start = 1'b0;
      took = 0;
      idle_run = (expected_q.size() == 0 && !busy && !start) ? idle_run + 1 : 0;
      if (!start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          e = pending_q[0];
          case (e.kind)
            K_CMD: begin
              in_flight = e;
              op_i = e.op; proc_id_i = e.id; req_size_i = e.size; fit_mode_i = e.mode;
              start = 1'b1;
              gap_left = e.gap;
              void'(pending_q.pop_front());
            end
            K_CFG: if (idle_run >= SETTLE) begin
              cfg_we_i = 1'b1;
              cfg_wdata_i = e.cfg;
              table_reset(e.cfg);
              void'(pending_q.pop_front());
            end
            default: if (idle_run >= SETTLE) void'(pending_q.pop_front());
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  int idle_odds;   // chance in percent that a command is followed by a gap

  function automatic void add_cmd(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                  logic [REQ_W-1:0] size, logic [MODE_W-1:0] mode);
    entry_t e;
    e.kind = K_CMD; e.op = op; e.id = id; e.size = size; e.mode = mode; e.cfg = '0;
    e.gap = ($urandom_range(99) < idle_odds) ? $urandom_range(4) : 0;
    pending_q.push_back(e);
  endfunction

  function automatic void add_cfg(logic [CFG_W-1:0] value);
    entry_t e;
    e.kind = K_CFG; e.cfg = value; e.op = OP_STATUS; e.id = '0; e.size = '0;
    e.mode = FIT_FIRST; e.gap = 0;
    pending_q.push_back(e);
  endfunction

  function automatic void add_drain();
    entry_t e;
    e.kind = K_DRAIN; e.cfg = '0; e.op = OP_STATUS; e.id = '0; e.size = '0;
    e.mode = FIT_FIRST; e.gap = 0;
    pending_q.push_back(e);
  endfunction

  // Random phase: mostly requests and releases over a small id pool.
  function automatic void add_random_phase(int count, longint space);
    int pick;
    logic [REQ_W-1:0] sz;
    logic [ID_W-1:0] id;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      id = ($urandom_range(9) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(11));
      if (pick < 50) begin
        case ($urandom_range(9))
          0: sz = REQ_W'($urandom);
          1: sz = 0;
          2: sz = REQ_W'(space);
          default: sz = REQ_W'($urandom_range(space / 6 + 1, 1));
        endcase
        add_cmd(OP_REQUEST, id, sz,
                ($urandom_range(19) == 0) ? MODE_W'(3) : MODE_W'($urandom_range(2)));
      end else if (pick < 78) begin
        add_cmd(OP_RELEASE, id, REQ_W'($urandom), MODE_W'($urandom));
      end else if (pick < 88) begin
        add_cmd(OP_COMPACT, ID_W'($urandom), REQ_W'($urandom), MODE_W'($urandom));
      end else begin
        add_cmd(OP_STATUS, ID_W'($urandom), REQ_W'($urandom), MODE_W'($urandom));
      end
    end
  endfunction

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_wdata_i = '0;
    start = 1'b0; op_i = OP_STATUS; proc_id_i = '0; req_size_i = '0; fit_mode_i = FIT_FIRST;
    mismatches = 0; cycles = 0; took = 0; gap_left = 0; idle_run = 0;
    table_reset(CFG_W'(SPACE_CAP));
    idle_odds = 50;

    // Directed: reset size, oversized request, zero request, bad fit mode, exact fit of the whole space, releases.
    add_cmd(OP_STATUS, '0, '0, FIT_FIRST);
    add_cmd(OP_REQUEST, 16'hFFFF, 21'h1FFFFF, FIT_FIRST);
    add_cmd(OP_REQUEST, 16'd1, 21'd0, FIT_BEST);
    add_cmd(OP_REQUEST, 16'd1, 21'd5, MODE_W'(3));
    add_cmd(OP_REQUEST, 16'hFFFF, REQ_W'(SPACE_CAP), FIT_WORST);
    add_cmd(OP_RELEASE, 16'd7, '0, FIT_FIRST);
    add_cmd(OP_RELEASE, 16'hFFFF, '0, FIT_FIRST);
    // Zero size acts as one unit.
    add_cfg('0);
    add_cmd(OP_REQUEST, 16'd3, 21'd1, FIT_FIRST);
    add_cmd(OP_REQUEST, 16'd4, 21'd1, FIT_FIRST);
    add_cmd(OP_STATUS, '0, '0, FIT_FIRST);
    // Oversized setting saturates; then a fragmented table for the fit rules.
    add_cfg(21'h1FFFFF);
    add_cmd(OP_REQUEST, 16'd1, 21'd100, FIT_FIRST);
    add_cmd(OP_REQUEST, 16'd2, 21'd30, FIT_FIRST);
    add_cmd(OP_REQUEST, 16'd3, 21'd50, FIT_FIRST);
    add_cmd(OP_REQUEST, 16'd4, 21'd10, FIT_FIRST);
    add_cmd(OP_RELEASE, 16'd1, '0, FIT_FIRST);
    add_cmd(OP_RELEASE, 16'd3, '0, FIT_FIRST);
    add_cmd(OP_REQUEST, 16'd5, 21'd40, FIT_BEST);
    add_cmd(OP_REQUEST, 16'd6, 21'd20, FIT_WORST);
    add_cmd(OP_REQUEST, 16'd7, 21'd5, FIT_FIRST);
    add_cmd(OP_RELEASE, 16'd2, '0, FIT_FIRST);
    add_cmd(OP_COMPACT, '0, '0, FIT_FIRST);
    add_cmd(OP_STATUS, '0, '0, FIT_FIRST);

    // Table full: a small space cut into one-unit blocks fills all 64 entries.
    add_cfg(21'd66);
    idle_odds = 0;
    for (int i = 0; i < 65; i++) add_cmd(OP_REQUEST, ID_W'(i), 21'd1, FIT_FIRST);
    add_cmd(OP_REQUEST, 16'd99, 21'd1, FIT_BEST);   // split refused
    add_cmd(OP_REQUEST, 16'd99, 21'd3, FIT_FIRST);  // exact fit of the tail
    add_cmd(OP_STATUS, '0, '0, FIT_FIRST);
    add_cmd(OP_RELEASE, 16'd10, '0, FIT_FIRST);
    add_cmd(OP_RELEASE, 16'd12, '0, FIT_FIRST);
    add_cmd(OP_COMPACT, '0, '0, FIT_FIRST);         // compact with a used tail
    add_cmd(OP_STATUS, '0, '0, FIT_FIRST);

    idle_odds = 60;
    add_cfg(21'd4000);
    add_random_phase(70, 4000);
    add_drain();                                    // sender holds until all results are in
    add_random_phase(30, 4000);
    idle_odds = 0;
    add_cfg(21'd200);
    add_random_phase(70, 200);
    idle_odds = 60;
    add_cfg(21'd1);
    add_random_phase(10, 1);
    add_cfg(REQ_W'(SPACE_CAP - 1));
    add_random_phase(60, SPACE_CAP - 1);
    add_cfg(REQ_W'(SPACE_CAP));
    add_random_phase(50, SPACE_CAP);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_q.size() == 0 && !start && expected_q.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
